// ===== rtl/prbt_pkg.sv =====
package prbt_pkg;

  localparam int unsigned MaxPackets = 4096;
  localparam int unsigned ListBurst  = 64;
  localparam int unsigned StoreBytes = (MaxPackets + 7) / 8;
  localparam int unsigned AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  localparam int unsigned TotW  = 13;
  localparam int unsigned SeqW  = 13;
  localparam int unsigned MseqW = 12;
  localparam int unsigned CntW  = 13;
  localparam int unsigned IdxW  = SeqW - 3;
  localparam int unsigned NbW   = TotW - 2;
  localparam int unsigned NumW  = $clog2(ListBurst + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_COUNT = 2'd2,
    ACT_LIST  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_MRD,
    ST_MWR,
    ST_CRD,
    ST_CAC,
    ST_LRD,
    ST_LLD,
    ST_LEM,
    ST_FIN
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [SeqW-1:0]     seq;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [MseqW-1:0]    missing_seq;
    logic                found;
    logic [CntW-1:0]     missing_count;
    logic                xfer_done;
    logic                last;
  } rsp_t;

endpackage

// ===== rtl/prbt_ram.sv =====
module prbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                             wdata_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/packet_receipt_bitmap_tracker.sv =====
// Channel  Ports                              Handshake
// config   cfg_we_i, cfg_wdata_i              write at edge with cfg_we_i high
// request  start, busy, req_i                 accepted at edge with start && !busy
// result   result_valid_o, rsp_o              one cycle per result, no stall
//
// One single-port byte RAM with registered read is walked by a small sequencer.
// Mark: read, then write back (read-modify-write); out-of-range mark, list past the
// end and count with no packets answer straight from idle. Clear: one RAM write per
// byte over all StoreBytes bytes. Count: a read and an accumulate step per byte in use.
// List: read and load per byte scanned, one emit per hit (one if none), then finish.
// After reset a clearing pass over all StoreBytes bytes holds busy high.
// The receiver cannot stall; config writes land at once.
module packet_receipt_bitmap_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [prbt_pkg::TotW-1:0]   cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  prbt_pkg::req_t              req_i,
  output logic                        result_valid_o,
  output prbt_pkg::rsp_t              rsp_o
);

  prbt_pkg::state_e state_q, state_d;

  logic [prbt_pkg::TotW-1:0]  cfg_q;
  logic [prbt_pkg::AddrW-1:0] clr_q, clr_d;
  logic                       report_q, report_d;
  logic                       done_q, done_d;
  logic [prbt_pkg::SeqW-1:0]  seq_q, seq_d;
  logic [prbt_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [prbt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]                 pend_q, pend_d;
  logic                       first_q, first_d;
  logic [prbt_pkg::NumW-1:0]  num_q, num_d;
  logic [prbt_pkg::MseqW-1:0] prev_q, prev_d;
  logic                       prev_v_q, prev_v_d;
  prbt_pkg::rsp_t             rsp_q, rsp_d;
  logic                       rsp_valid_q, rsp_valid_d;

  logic                       ram_we;
  logic [prbt_pkg::AddrW-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;

  logic                       accept;
  logic [prbt_pkg::TotW-1:0]  t_eff;
  logic [prbt_pkg::TotW:0]    t_sum;
  logic [prbt_pkg::NbW-1:0]   nbytes;
  logic                       mark_oor;
  logic                       list_none;
  logic                       last_byte;
  logic [7:0]                 cnt_bits;
  logic [3:0]                 pop;
  logic [prbt_pkg::CntW-1:0]  cnt_new;
  logic [2:0]                 low_b;
  logic [7:0]                 pend_after;
  logic                       burst_full;
  logic                       clr_end;

  function automatic logic [7:0] vmask(input logic [prbt_pkg::IdxW-1:0] i,
                                       input logic [prbt_pkg::TotW-1:0] t);
    logic [prbt_pkg::IdxW-1:0] tb;
    logic [15:0]               m;
    tb = t[prbt_pkg::TotW-1:3];
    m  = (16'd1 << t[2:0]) - 16'd1;
    if (i < tb) begin
      return 8'hFF;
    end else if (i == tb) begin
      return m[7:0];
    end else begin
      return 8'h00;
    end
  endfunction

  prbt_ram #(
    .Width(8),
    .Depth(prbt_pkg::StoreBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (32'(cfg_q) > prbt_pkg::MaxPackets) begin
      t_eff = prbt_pkg::TotW'(prbt_pkg::MaxPackets);
    end else begin
      t_eff = cfg_q;
    end
  end

  assign accept     = start && !busy;
  assign t_sum      = {1'b0, t_eff} + (prbt_pkg::TotW+1)'(7);
  assign nbytes     = t_sum[prbt_pkg::TotW:3];
  assign mark_oor   = {1'b0, req_i.seq[prbt_pkg::SeqW-1:3]} >= nbytes;
  assign list_none  = req_i.seq >= t_eff;
  assign last_byte  = ({1'b0, idx_q} + prbt_pkg::NbW'(1)) >= nbytes;
  assign cnt_bits   = ~ram_rdata & vmask(idx_q, t_eff);
  assign cnt_new    = cnt_q + prbt_pkg::CntW'(pop);
  assign pend_after = pend_q & ~(8'd1 << low_b);
  assign burst_full = ({1'b0, num_q} + (prbt_pkg::NumW+1)'(1))
                      == (prbt_pkg::NumW+1)'(prbt_pkg::ListBurst);
  assign clr_end    = clr_q == prbt_pkg::AddrW'(prbt_pkg::StoreBytes - 1);

  always_comb begin
    pop = '0;
    for (int b = 0; b < 8; b++) begin
      pop = pop + 4'(cnt_bits[b]);
    end
  end

  always_comb begin
    low_b = '0;
    for (int b = 7; b >= 0; b--) begin
      if (pend_q[b]) begin
        low_b = 3'(b);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      prbt_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.action)
            prbt_pkg::ACT_CLEAR: state_d = prbt_pkg::ST_CLR;
            prbt_pkg::ACT_MARK:  state_d = mark_oor ? prbt_pkg::ST_IDLE : prbt_pkg::ST_MRD;
            prbt_pkg::ACT_COUNT: state_d = (t_eff == '0) ? prbt_pkg::ST_IDLE
                                                         : prbt_pkg::ST_CRD;
            prbt_pkg::ACT_LIST:  state_d = list_none ? prbt_pkg::ST_IDLE : prbt_pkg::ST_LRD;
            default:             state_d = prbt_pkg::ST_IDLE;
          endcase
        end
      end
      prbt_pkg::ST_CLR: if (clr_end) state_d = prbt_pkg::ST_IDLE;
      prbt_pkg::ST_MRD: state_d = prbt_pkg::ST_MWR;
      prbt_pkg::ST_MWR: state_d = prbt_pkg::ST_IDLE;
      prbt_pkg::ST_CRD: state_d = prbt_pkg::ST_CAC;
      prbt_pkg::ST_CAC: state_d = last_byte ? prbt_pkg::ST_IDLE : prbt_pkg::ST_CRD;
      prbt_pkg::ST_LRD: state_d = prbt_pkg::ST_LLD;
      prbt_pkg::ST_LLD: state_d = prbt_pkg::ST_LEM;
      prbt_pkg::ST_LEM: begin
        if (pend_q == '0) begin
          state_d = last_byte ? prbt_pkg::ST_FIN : prbt_pkg::ST_LRD;
        end else if (burst_full) begin
          state_d = prbt_pkg::ST_FIN;
        end else if (pend_after == '0) begin
          state_d = last_byte ? prbt_pkg::ST_FIN : prbt_pkg::ST_LRD;
        end
      end
      prbt_pkg::ST_FIN: state_d = prbt_pkg::ST_IDLE;
      default:          state_d = prbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    report_d    = report_q;
    done_d      = done_q;
    seq_d       = seq_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    first_d     = first_q;
    num_d       = num_q;
    prev_d      = prev_q;
    prev_v_d    = prev_v_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    rsp_d.xfer_done = done_q;
    rsp_d.last  = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;

    case (state_q)
      prbt_pkg::ST_IDLE: begin
        if (accept) begin
          seq_d = req_i.seq;
          case (req_i.action)
            prbt_pkg::ACT_CLEAR: begin
              clr_d    = '0;
              report_d = 1'b1;
              done_d   = 1'b0;
            end
            prbt_pkg::ACT_MARK: begin
              if (mark_oor) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = 1'b1;
              end
            end
            prbt_pkg::ACT_COUNT: begin
              idx_d = '0;
              cnt_d = '0;
              if (t_eff == '0) begin
                done_d          = 1'b1;
                rsp_valid_d     = 1'b1;
                rsp_d.xfer_done = 1'b1;
              end
            end
            prbt_pkg::ACT_LIST: begin
              idx_d    = req_i.seq[prbt_pkg::SeqW-1:3];
              first_d  = 1'b1;
              num_d    = '0;
              prev_v_d = 1'b0;
              if (list_none) begin
                rsp_valid_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      prbt_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + prbt_pkg::AddrW'(1);
        if (clr_end) begin
          rsp_valid_d = report_q;
          report_d    = 1'b0;
        end
      end
      prbt_pkg::ST_MRD: begin
        ram_addr = prbt_pkg::AddrW'(seq_q[prbt_pkg::SeqW-1:3]);
      end
      prbt_pkg::ST_MWR: begin
        ram_we      = 1'b1;
        ram_addr    = prbt_pkg::AddrW'(seq_q[prbt_pkg::SeqW-1:3]);
        ram_wdata   = ram_rdata | (8'd1 << seq_q[2:0]);
        rsp_valid_d = 1'b1;
      end
      prbt_pkg::ST_CRD: begin
        ram_addr = prbt_pkg::AddrW'(idx_q);
      end
      prbt_pkg::ST_CAC: begin
        cnt_d = cnt_new;
        idx_d = idx_q + prbt_pkg::IdxW'(1);
        if (last_byte) begin
          rsp_valid_d         = 1'b1;
          rsp_d.missing_count = cnt_new;
          if (cnt_new == '0) begin
            done_d          = 1'b1;
            rsp_d.xfer_done = 1'b1;
          end
        end
      end
      prbt_pkg::ST_LRD: begin
        ram_addr = prbt_pkg::AddrW'(idx_q);
      end
      prbt_pkg::ST_LLD: begin
        pend_d  = ~ram_rdata & vmask(idx_q, t_eff) & (first_q ? (8'hFF << seq_q[2:0]) : 8'hFF);
        first_d = 1'b0;
      end
      prbt_pkg::ST_LEM: begin
        if (pend_q == '0) begin
          idx_d = idx_q + prbt_pkg::IdxW'(1);
        end else begin
          if (prev_v_q) begin
            rsp_valid_d       = 1'b1;
            rsp_d.found       = 1'b1;
            rsp_d.missing_seq = prev_q;
            rsp_d.last        = 1'b0;
          end
          prev_d   = prbt_pkg::MseqW'({idx_q, low_b});
          prev_v_d = 1'b1;
          num_d    = num_q + prbt_pkg::NumW'(1);
          pend_d   = pend_after;
          if (!burst_full && pend_after == '0) begin
            idx_d = idx_q + prbt_pkg::IdxW'(1);
          end
        end
      end
      prbt_pkg::ST_FIN: begin
        rsp_valid_d = 1'b1;
        if (prev_v_q) begin
          rsp_d.found       = 1'b1;
          rsp_d.missing_seq = prev_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prbt_pkg::ST_CLR;
      cfg_q       <= prbt_pkg::TotW'(4096);
      clr_q       <= '0;
      report_q    <= 1'b0;
      done_q      <= 1'b0;
      first_q     <= 1'b0;
      num_q       <= '0;
      prev_v_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      clr_q       <= clr_d;
      report_q    <= report_d;
      done_q      <= done_d;
      first_q     <= first_d;
      num_q       <= num_d;
      prev_v_q    <= prev_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    pend_q <= pend_d;
    prev_q <= prev_d;
    rsp_q  <= rsp_d;
  end

  assign busy           = state_q != prbt_pkg::ST_IDLE;
  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  class bitmap_scoreboard;
    bit              rx_map [prbt_pkg::MaxPackets];
    bit              done_flag;
    int unsigned     total;
    int unsigned     errors;
    prbt_pkg::rsp_t  rsp_pending_q[$];

    function new();
      total = prbt_pkg::MaxPackets;
    endfunction

    function void set_total(logic [prbt_pkg::TotW-1:0] v);
      total = 32'(v);
    endfunction

    function int unsigned eff_total();
      return (total > prbt_pkg::MaxPackets) ? prbt_pkg::MaxPackets : total;
    endfunction

    function int unsigned pending();
      return rsp_pending_q.size();
    endfunction

    function void push_rsp(bit status, int unsigned mseq, bit found, int unsigned mcount,
                           bit last);
      prbt_pkg::rsp_t r;
      r.status        = status;
      r.missing_seq   = prbt_pkg::MseqW'(mseq);
      r.found         = found;
      r.missing_count = prbt_pkg::CntW'(mcount);
      r.xfer_done     = done_flag;
      r.last          = last;
      rsp_pending_q.push_back(r);
    endfunction

    function void note_request(prbt_pkg::req_t r);
      int unsigned t, s, n, cnt;
      t = eff_total();
      case (r.action)
        prbt_pkg::ACT_CLEAR: begin
          foreach (rx_map[i]) rx_map[i] = 1'b0;
          done_flag = 1'b0;
          push_rsp(1'b0, 0, 1'b0, 0, 1'b1);
        end
        prbt_pkg::ACT_MARK: begin
          if ((r.seq >> 3) >= (t + 7) / 8) begin
            push_rsp(1'b1, 0, 1'b0, 0, 1'b1);
          end else begin
            rx_map[r.seq] = 1'b1;
            push_rsp(1'b0, 0, 1'b0, 0, 1'b1);
          end
        end
        prbt_pkg::ACT_COUNT: begin
          cnt = 0;
          for (s = 0; s < t; s++) if (!rx_map[s]) cnt++;
          if (cnt == 0) done_flag = 1'b1;
          push_rsp(1'b0, 0, 1'b0, cnt, 1'b1);
        end
        default: begin
          n = 0;
          for (s = 32'(r.seq); s < t && n < prbt_pkg::ListBurst; s++) begin
            if (!rx_map[s]) begin
              push_rsp(1'b0, s, 1'b1, 0, 1'b0);
              n++;
            end
          end
          if (n == 0) push_rsp(1'b0, 0, 1'b0, 0, 1'b1);
          else rsp_pending_q[rsp_pending_q.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_response(prbt_pkg::rsp_t act);
      prbt_pkg::rsp_t exp;
      if (rsp_pending_q.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %h", $time, act);
        errors++;
        return;
      end
      exp = rsp_pending_q.pop_front();
      check_field("status", 32'(exp.status), 32'(act.status));
      check_field("missing_seq", 32'(exp.missing_seq), 32'(act.missing_seq));
      check_field("found", 32'(exp.found), 32'(act.found));
      check_field("missing_count", 32'(exp.missing_count), 32'(act.missing_count));
      check_field("xfer_done", 32'(exp.xfer_done), 32'(act.xfer_done));
      check_field("last", 32'(exp.last), 32'(act.last));
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [prbt_pkg::TotW-1:0] cfg_wdata_i;
  logic                      start;
  logic                      busy;
  prbt_pkg::req_t            req_i;
  logic                      result_valid_o;
  prbt_pkg::rsp_t            rsp_o;

  bitmap_scoreboard sb;
  bit               idle_on;

  packet_receipt_bitmap_tracker u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // note the transaction first so a same-edge result still finds its expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(req_i);
      if (result_valid_o) sb.check_response(rsp_o);
    end
  end

  task automatic send_request(prbt_pkg::action_e a, int unsigned s);
    prbt_pkg::req_t r;
    r.action = a;
    r.seq    = prbt_pkg::SeqW'(s);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (idle_on && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_total(int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= prbt_pkg::TotW'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_total(prbt_pkg::TotW'(v));
  endtask

  task automatic random_request();
    int unsigned roll, lim;
    roll = $urandom_range(0, 99);
    lim  = ((sb.eff_total() + 7) / 8) * 8 + 2;
    if (roll < 8) begin
      send_request(prbt_pkg::action_e'($urandom_range(0, 3)), $urandom_range(0, 8191));
    end else if (roll < 55) begin
      send_request(prbt_pkg::ACT_MARK, $urandom_range(0, lim));
    end else if (roll < 72) begin
      send_request(prbt_pkg::ACT_COUNT, $urandom_range(0, 8191));
    end else if (roll < 94) begin
      send_request(prbt_pkg::ACT_LIST, $urandom_range(0, lim));
    end else begin
      send_request(prbt_pkg::ACT_CLEAR, $urandom_range(0, 8191));
    end
  endtask

  initial begin
    int unsigned ph, k, t;
    sb          = new();
    idle_on     = 1'b1;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // reset total, full-size bitmap
    send_request(prbt_pkg::ACT_COUNT, 0);
    send_request(prbt_pkg::ACT_LIST, 0);
    send_request(prbt_pkg::ACT_MARK, 0);
    send_request(prbt_pkg::ACT_MARK, 4095);
    send_request(prbt_pkg::ACT_MARK, 4096);
    send_request(prbt_pkg::ACT_MARK, 8191);
    send_request(prbt_pkg::ACT_LIST, 4090);
    send_request(prbt_pkg::ACT_LIST, 8191);
    send_request(prbt_pkg::ACT_LIST, 4095);
    send_request(prbt_pkg::ACT_CLEAR, 0);
    send_request(prbt_pkg::ACT_COUNT, 0);
    drain();

    // no packets at all
    write_total(0);
    send_request(prbt_pkg::ACT_MARK, 0);
    send_request(prbt_pkg::ACT_COUNT, 0);
    send_request(prbt_pkg::ACT_LIST, 0);
    send_request(prbt_pkg::ACT_MARK, 5);
    send_request(prbt_pkg::ACT_CLEAR, 0);
    drain();

    // single packet, rounded-up byte accepts marks up to 7
    write_total(1);
    send_request(prbt_pkg::ACT_MARK, 7);
    send_request(prbt_pkg::ACT_MARK, 8);
    send_request(prbt_pkg::ACT_COUNT, 0);
    send_request(prbt_pkg::ACT_MARK, 0);
    send_request(prbt_pkg::ACT_COUNT, 0);
    send_request(prbt_pkg::ACT_LIST, 0);
    drain();

    // above capacity saturates
    write_total(8191);
    send_request(prbt_pkg::ACT_COUNT, 0);
    send_request(prbt_pkg::ACT_LIST, 0);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: t = 1;
        1: t = 4096;
        2: t = $urandom_range(2, 16);
        3: t = 0;
        5: t = 8191;
        default: t = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 300)
                                                 : $urandom_range(1, 48);
      endcase
      write_total(t);
      idle_on = (ph != 4);
      for (k = 0; k < 48; k++) random_request();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/prbt_pkg.sv
rtl/prbt_ram.sv
rtl/packet_receipt_bitmap_tracker.sv
tb/sv/tb.sv
